FILE: rtl/dvu_pkg.sv
`timescale 1ns / 1ps

package dvu_pkg;

	localparam int NODE_COUNT = 4;
	localparam int COST_W     = 10;
	localparam int ID_W       = 2;
	localparam int NODE_IDX_W = $clog2(NODE_COUNT);
	localparam int CFG_IDX_W  = 3;

	localparam logic [COST_W-1:0] INF_COST = COST_W'(999);

	typedef logic [COST_W-1:0] cost_t;
	typedef logic [ID_W-1:0]   node_id_t;
	typedef cost_t [NODE_COUNT-1:0] cost_vec_t;
	typedef logic [NODE_COUNT-1:0] node_mask_t;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_NODE_ID   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOR_MASK = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_LINK_COST_0   = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_LINK_COST_LAST = CFG_IDX_W'(2 + NODE_COUNT - 1);

endpackage

FILE: rtl/distance_vector_update.sv
`timescale 1ns / 1ps

// Channel  Handshake              Payload
// -------  ---------------------  --------------------------------------------------
// in       in_valid / in_ready    sender_id, peer_cost_0..3
// out      out_valid / out_ready  from_node, to_node, best_cost_0..3, last_packet
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data (cfg_ready is always high)
//
// An accepted item waits in the input register; the relaxation, the table update and the
// loading of the packet register happen in the cycle it leaves it.
// The packet register sends one packet per cycle while out_ready is high: for an item that
// updates a cost with a nonempty mask, one per neighbor bit set (1 to 4); others send none.
// A new item is accepted while the previous burst drains; it waits in the input
// register only if it also triggers a burst and the current one has not finished.
// Reset sets every learned and link cost to unreachable and clears the id and mask.
module distance_vector_update (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [dvu_pkg::ID_W-1:0]         sender_id,
	input  logic [dvu_pkg::COST_W-1:0]       peer_cost_0,
	input  logic [dvu_pkg::COST_W-1:0]       peer_cost_1,
	input  logic [dvu_pkg::COST_W-1:0]       peer_cost_2,
	input  logic [dvu_pkg::COST_W-1:0]       peer_cost_3,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [dvu_pkg::ID_W-1:0]         from_node,
	output logic [dvu_pkg::ID_W-1:0]         to_node,
	output logic [dvu_pkg::COST_W-1:0]       best_cost_0,
	output logic [dvu_pkg::COST_W-1:0]       best_cost_1,
	output logic [dvu_pkg::COST_W-1:0]       best_cost_2,
	output logic [dvu_pkg::COST_W-1:0]       best_cost_3,
	output logic                             last_packet,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [dvu_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dvu_pkg::COST_W-1:0]       cfg_data
);
	import dvu_pkg::*;

	// configuration
	node_id_t   own_id_q;
	node_mask_t nbr_mask_q;
	cost_vec_t  link_q;

	// routing state
	cost_vec_t  learned_q;

	// input register
	logic       valid_s1;
	node_id_t   sender_s1;
	cost_vec_t  peer_s1;

	// packet register
	node_mask_t pkt_mask_q;
	node_id_t   pkt_from_q;
	cost_vec_t  pkt_best_q;

	cost_t      to_sender;
	logic       reach;
	logic [COST_W:0] sum [NODE_COUNT];
	cost_vec_t  best_cur;
	cost_vec_t  learned_nxt;
	cost_vec_t  best_nxt;
	node_mask_t upd;
	logic       emit;
	logic       burst_done;
	logic       commit;
	logic       in_fire;
	logic       out_fire;
	logic [CFG_IDX_W-1:0] link_sel;
	node_id_t   low_idx;

	assign cfg_ready = 1'b1;
	assign link_sel  = cfg_index - CFG_LINK_COST_0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q   <= '0;
			nbr_mask_q <= '0;
			for (int d = 0; d < NODE_COUNT; d++) begin
				link_q[d] <= INF_COST;
			end
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index) inside
				CFG_OWN_NODE_ID:   own_id_q   <= cfg_data[ID_W-1:0];
				CFG_NEIGHBOR_MASK: nbr_mask_q <= cfg_data[NODE_COUNT-1:0];
				[CFG_LINK_COST_0:CFG_LINK_COST_LAST]: link_q[link_sel[NODE_IDX_W-1:0]] <= cfg_data;
				default: ;
			endcase
		end
	end

	// relaxation through the sender
	always_comb begin
		to_sender = (link_q[sender_s1] < learned_q[sender_s1]) ?
			link_q[sender_s1] : learned_q[sender_s1];
		reach = (to_sender != INF_COST);
		for (int d = 0; d < NODE_COUNT; d++) begin
			best_cur[d] = (link_q[d] < learned_q[d]) ? link_q[d] : learned_q[d];
			sum[d] = {1'b0, peer_s1[d]} + {1'b0, to_sender};
			upd[d] = reach && (own_id_q != NODE_IDX_W'(d)) && (sum[d] < {1'b0, best_cur[d]});
			learned_nxt[d] = upd[d] ? sum[d][COST_W-1:0] : learned_q[d];
			best_nxt[d] = (link_q[d] < learned_nxt[d]) ? link_q[d] : learned_nxt[d];
		end
	end

	assign emit       = (|upd) && (|nbr_mask_q);
	assign out_valid  = |pkt_mask_q;
	assign out_fire   = out_valid && out_ready;
	assign burst_done = !out_valid || (out_ready && last_packet);
	assign commit     = valid_s1 && (!emit || burst_done);
	assign in_ready   = !valid_s1 || commit;
	assign in_fire    = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (commit) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			sender_s1  <= sender_id;
			peer_s1[0] <= peer_cost_0;
			peer_s1[1] <= peer_cost_1;
			peer_s1[2] <= peer_cost_2;
			peer_s1[3] <= peer_cost_3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < NODE_COUNT; d++) begin
				learned_q[d] <= INF_COST;
			end
		end else if (commit) begin
			learned_q <= learned_nxt;
		end
	end

	// load a new burst, or drop the neighbor just served
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_mask_q <= '0;
		end else if (commit && emit) begin
			pkt_mask_q <= nbr_mask_q;
		end else if (out_fire) begin
			pkt_mask_q <= pkt_mask_q & (pkt_mask_q - NODE_COUNT'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (commit && emit) begin
			pkt_from_q <= own_id_q;
			pkt_best_q <= best_nxt;
		end
	end

	// lowest pending neighbor goes first
	always_comb begin
		low_idx = '0;
		for (int i = NODE_COUNT - 1; i >= 0; i--) begin
			if (pkt_mask_q[i]) begin
				low_idx = NODE_IDX_W'(i);
			end
		end
	end

	assign from_node   = pkt_from_q;
	assign to_node     = low_idx;
	assign best_cost_0 = pkt_best_q[0];
	assign best_cost_1 = pkt_best_q[1];
	assign best_cost_2 = pkt_best_q[2];
	assign best_cost_3 = pkt_best_q[3];
	assign last_packet = ((pkt_mask_q & (pkt_mask_q - NODE_COUNT'(1))) == '0);

`ifndef SYNTHESIS
	a_no_burst_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(commit && emit && out_valid && !(out_ready && last_packet)))
		else $error("burst loaded over unfinished burst");

	a_burst_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && last_packet && !(commit && emit)) |=> !out_valid)
		else $error("packets after last packet");

	a_learned_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(learned_q[0] <= INF_COST) && (learned_q[1] <= INF_COST) &&
		(learned_q[2] <= INF_COST) && (learned_q[3] <= INF_COST))
		else $error("learned cost above unreachable");

	a_learned_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> (learned_q[0] <= $past(learned_q[0])) &&
		(learned_q[1] <= $past(learned_q[1])) &&
		(learned_q[2] <= $past(learned_q[2])) &&
		(learned_q[3] <= $past(learned_q[3])))
		else $error("learned cost increased");
`endif

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

typedef struct packed {
	dvu_pkg::node_id_t  sender;
	dvu_pkg::cost_vec_t peer;
} advert_t;

typedef struct packed {
	dvu_pkg::node_id_t  src;
	dvu_pkg::node_id_t  dst;
	dvu_pkg::cost_vec_t cost;
	logic               last_flag;
} route_pkt_t;

class route_scoreboard;
	dvu_pkg::node_id_t   own_id;
	dvu_pkg::node_mask_t nbr_mask;
	dvu_pkg::cost_vec_t  link_cost;
	dvu_pkg::cost_vec_t  learned;
	route_pkt_t          pkt_q[$];
	int                  errors;

	function new();
		own_id = '0;
		nbr_mask = '0;
		errors = 0;
		for (int d = 0; d < dvu_pkg::NODE_COUNT; d++) begin
			link_cost[d] = dvu_pkg::INF_COST;
			learned[d] = dvu_pkg::INF_COST;
		end
	endfunction

	function dvu_pkg::cost_t best(int d);
		return (link_cost[d] < learned[d]) ? link_cost[d] : learned[d];
	endfunction

	function int pending();
		return pkt_q.size();
	endfunction

	function void write_reg(logic [dvu_pkg::CFG_IDX_W-1:0] idx, dvu_pkg::cost_t data);
		if (idx == dvu_pkg::CFG_OWN_NODE_ID)
			own_id = data[dvu_pkg::ID_W-1:0];
		else if (idx == dvu_pkg::CFG_NEIGHBOR_MASK)
			nbr_mask = data[dvu_pkg::NODE_COUNT-1:0];
		else if (idx >= dvu_pkg::CFG_LINK_COST_0 && idx <= dvu_pkg::CFG_LINK_COST_LAST)
			link_cost[idx - dvu_pkg::CFG_LINK_COST_0] = data;
	endfunction

	// relax every destination but the own node through the sender; on a change queue one packet per neighbor
	function void note_input(advert_t item);
		int to_sender;
		int sum;
		int last_i;
		bit changed;
		route_pkt_t pkt;
		changed = 0;
		to_sender = best(item.sender);
		if (to_sender != dvu_pkg::INF_COST) begin
			for (int d = 0; d < dvu_pkg::NODE_COUNT; d++) begin
				if (d == own_id)
					continue;
				sum = item.peer[d] + to_sender;
				if (sum < best(d)) begin
					learned[d] = dvu_pkg::cost_t'(sum);
					changed = 1;
				end
			end
		end
		if (!changed)
			return;
		last_i = -1;
		for (int i = 0; i < dvu_pkg::NODE_COUNT; i++)
			if (nbr_mask[i])
				last_i = i;
		for (int i = 0; i < dvu_pkg::NODE_COUNT; i++) begin
			if (nbr_mask[i]) begin
				pkt.src = own_id;
				pkt.dst = dvu_pkg::node_id_t'(i);
				for (int d = 0; d < dvu_pkg::NODE_COUNT; d++)
					pkt.cost[d] = best(d);
				pkt.last_flag = (i == last_i);
				pkt_q.push_back(pkt);
			end
		end
	endfunction

	function void report(string field, logic [dvu_pkg::COST_W-1:0] want,
			logic [dvu_pkg::COST_W-1:0] got);
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		errors++;
	endfunction

	function void check_result(route_pkt_t got);
		route_pkt_t want;
		if (pkt_q.size() == 0) begin
			$display("%0t: unexpected packet, expected none, actual from %0d to %0d",
				$time, got.src, got.dst);
			errors++;
			return;
		end
		want = pkt_q.pop_front();
		if (got.src !== want.src)
			report("from_node", dvu_pkg::COST_W'(want.src), dvu_pkg::COST_W'(got.src));
		if (got.dst !== want.dst)
			report("to_node", dvu_pkg::COST_W'(want.dst), dvu_pkg::COST_W'(got.dst));
		for (int d = 0; d < dvu_pkg::NODE_COUNT; d++)
			if (got.cost[d] !== want.cost[d])
				report($sformatf("best_cost_%0d", d), want.cost[d], got.cost[d]);
		if (got.last_flag !== want.last_flag)
			report("last_packet", dvu_pkg::COST_W'(want.last_flag),
				dvu_pkg::COST_W'(got.last_flag));
	endfunction
endclass

module testbench;
	import dvu_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS   = 130;
	localparam int PHASES         = 5;
	localparam int SETTLE_CYCLES  = 8;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	node_id_t sender_id;
	cost_t    peer_cost_0, peer_cost_1, peer_cost_2, peer_cost_3;
	logic     out_valid;
	logic     out_ready;
	node_id_t from_node;
	node_id_t to_node;
	cost_t    best_cost_0, best_cost_1, best_cost_2, best_cost_3;
	logic     last_packet;
	logic     cfg_valid;
	logic     cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	cost_t    cfg_data;

	route_scoreboard sb;
	bit sender_idle;
	bit sink_idle;
	int hold_len;
	int quiet_cycles = 0;

	always #2 clk = ~clk;

	distance_vector_update u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sender_id   (sender_id),
		.peer_cost_0 (peer_cost_0),
		.peer_cost_1 (peer_cost_1),
		.peer_cost_2 (peer_cost_2),
		.peer_cost_3 (peer_cost_3),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.from_node   (from_node),
		.to_node     (to_node),
		.best_cost_0 (best_cost_0),
		.best_cost_1 (best_cost_1),
		.best_cost_2 (best_cost_2),
		.best_cost_3 (best_cost_3),
		.last_packet (last_packet),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	function automatic advert_t adv(int s, int c0, int c1, int c2, int c3);
		advert_t item;
		item.sender = node_id_t'(s);
		item.peer[0] = cost_t'(c0);
		item.peer[1] = cost_t'(c1);
		item.peer[2] = cost_t'(c2);
		item.peer[3] = cost_t'(c3);
		return item;
	endfunction

	// mostly a vector that lowers one destination by a few units through a
	// reachable sender; otherwise noise, mostly high costs to save the budget
	function automatic advert_t aimed_advert();
		advert_t item;
		int senders[$];
		int targets[$];
		int s;
		int d;
		int to_s;
		int room;
		int step;
		bit full_range;
		full_range = ($urandom_range(0, 3) == 0);
		item.sender = node_id_t'($urandom_range(0, NODE_COUNT - 1));
		for (int k = 0; k < NODE_COUNT; k++)
			item.peer[k] = full_range ? cost_t'($urandom_range(0, 1023))
			                          : cost_t'($urandom_range(512, 1023));
		for (int k = 0; k < NODE_COUNT; k++)
			if (sb.best(k) != INF_COST)
				senders.push_back(k);
		if ($urandom_range(0, 3) != 0 && senders.size() > 0) begin
			s = senders[$urandom_range(0, senders.size() - 1)];
			to_s = sb.best(s);
			for (int k = 0; k < NODE_COUNT; k++)
				if (k != sb.own_id && sb.best(k) > to_s)
					targets.push_back(k);
			if (targets.size() > 0) begin
				d = targets[$urandom_range(0, targets.size() - 1)];
				room = sb.best(d) - to_s;
				step = $urandom_range(1, (room < 4) ? room : 4);
				item.sender = node_id_t'(s);
				for (int k = 0; k < NODE_COUNT; k++)
					item.peer[k] = cost_t'(1023 - $urandom_range(0, 15));
				item.peer[d] = cost_t'(sb.best(d) - step - to_s);
			end
		end
		return item;
	endfunction

	task automatic send_advert(advert_t item);
		int gap;
		gap = sender_idle ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		sender_id = item.sender;
		peer_cost_0 = item.peer[0];
		peer_cost_1 = item.peer[1];
		peer_cost_2 = item.peer[2];
		peer_cost_3 = item.peer[3];
		do @(posedge clk); while (!in_ready);
		sb.note_input(item);
		@(negedge clk);
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, cost_t data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// drain all packets, then give a vector still in flight time to finish
	task automatic settle();
		in_valid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic configure_phase(int p);
		int pick;
		cost_t lc;
		if (p == 0) begin
			write_cfg(CFG_OWN_NODE_ID, cost_t'(10'h3FF));
			write_cfg(CFG_NEIGHBOR_MASK, cost_t'(10'h3FF));
		end else begin
			write_cfg(CFG_OWN_NODE_ID, cost_t'($urandom_range(0, NODE_COUNT - 1)));
			if (p == 1)
				write_cfg(CFG_NEIGHBOR_MASK, cost_t'(0));
			else if (p == 2)
				write_cfg(CFG_NEIGHBOR_MASK, cost_t'(15));
			else
				write_cfg(CFG_NEIGHBOR_MASK, cost_t'($urandom_range(1, 15)));
		end
		for (int d = 0; d < NODE_COUNT; d++) begin
			pick = $urandom_range(0, 7);
			if (pick == 0)
				lc = cost_t'(0);
			else if (pick == 1)
				lc = cost_t'(1023);
			else if (pick == 2)
				lc = INF_COST;
			else
				lc = cost_t'($urandom_range(200, 999));
			write_cfg(CFG_IDX_W'(CFG_LINK_COST_0 + d), lc);
		end
		// indexes past the register list must be dropped
		if (p == 3) begin
			write_cfg(CFG_IDX_W'(CFG_LINK_COST_LAST + 1), cost_t'(0));
			write_cfg(CFG_IDX_W'(CFG_LINK_COST_LAST + 2), cost_t'(1023));
		end
	endtask

	initial begin
		route_pkt_t got;
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_len > 0) begin
				out_ready = 1'b0;
				repeat (hold_len) @(negedge clk);
				hold_len = 0;
			end
			stall = sink_idle ? $urandom_range(0, 6) : 0;
			if (stall > 0) begin
				out_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
			got.src = from_node;
			got.dst = to_node;
			got.cost[0] = best_cost_0;
			got.cost[1] = best_cost_1;
			got.cost[2] = best_cost_2;
			got.cost[3] = best_cost_3;
			got.last_flag = last_packet;
			sb.check_result(got);
		end
	end

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		sender_id = '0;
		peer_cost_0 = '0;
		peer_cost_1 = '0;
		peer_cost_2 = '0;
		peer_cost_3 = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sender_idle = 1'b1;
		sink_idle = 1'b1;
		hold_len = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// everything unreachable out of reset
		send_advert(adv(1, 0, 0, 0, 0));
		settle();
		write_cfg(CFG_OWN_NODE_ID, cost_t'(0));
		write_cfg(CFG_NEIGHBOR_MASK, cost_t'(15));
		write_cfg(CFG_LINK_COST_0, cost_t'(0));
		write_cfg(CFG_IDX_W'(CFG_LINK_COST_0 + 1), cost_t'(600));
		write_cfg(CFG_IDX_W'(CFG_LINK_COST_0 + 2), cost_t'(1023));
		write_cfg(CFG_LINK_COST_LAST, INF_COST);
		send_advert(adv(2, 0, 0, 0, 0));
		send_advert(adv(3, 1023, 1023, 1023, 1023));
		send_advert(adv(1, 1023, 0, 900, 1023));
		send_advert(adv(1, 1023, 0, 300, 398));
		send_advert(adv(0, 1023, 1023, 899, 1023));
		send_advert(adv(2, 1023, 1023, 1023, 1023));
		send_advert(adv(3, 0, 0, 0, 0));
		send_advert(adv(0, 1023, 600, 899, 998));
		send_advert(adv(2, 0, 0, 0, 0));
		// learning with no neighbors produces nothing
		settle();
		write_cfg(CFG_OWN_NODE_ID, cost_t'(3));
		write_cfg(CFG_NEIGHBOR_MASK, cost_t'(0));
		send_advert(adv(0, 1023, 590, 1023, 1023));
		// own node in the mask and a cheap self entry that must be skipped
		settle();
		write_cfg(CFG_NEIGHBOR_MASK, cost_t'(4'b1001));
		send_advert(adv(0, 1023, 580, 880, 0));
		settle();
		write_cfg(CFG_LINK_COST_LAST, cost_t'(0));
		send_advert(adv(3, 1023, 570, 870, 1023));
		send_advert(adv(1, 5, 1023, 1023, 1023));

		for (int p = 0; p < PHASES; p++) begin
			settle();
			sender_idle = (p != 2) && (p != 4);
			sink_idle = (p != 4);
			configure_phase(p);
			// stall the sink long enough to back up the input side
			if (p == 2)
				hold_len = 80;
			for (int n = 0; n < RANDOM_ITEMS / PHASES; n++)
				send_advert(aimed_advert());
		end
		settle();

		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

FILE: files.f
rtl/dvu_pkg.sv
rtl/distance_vector_update.sv
bench/testbench.sv
